### hdl/etnr_pkg.sv
package etnr_pkg;

  // Longest run of equal bits that one edge may produce.
  localparam int MAX_RUN = 32;
  // Width of a run length; it also bounds the quotient of the divider.
  localparam int QW = $clog2(MAX_RUN + 1);
  // Width of the divider step counter.
  localparam int KW = $clog2(QW);
  // Frame bit counter width: holds header_bits + 8 * payload_bytes.
  localparam int BCW = 20;
  // Width of the clip threshold (MAX_RUN + 1) * bit_period.
  localparam int CAPW = 16 + QW;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_BIT_PERIOD    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEADER_BITS   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PAYLOAD_BYTES = 2'd2;

  localparam logic [15:0] BIT_PERIOD_RST    = 16'd1000;
  localparam logic [7:0]  HEADER_BITS_RST   = 8'd3;
  localparam logic [15:0] PAYLOAD_BYTES_RST = 16'd13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAP,
    ST_CMP,
    ST_DIV,
    ST_EMIT
  } etnr_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic cap;
    logic cmp;
    logic div;
    logic step;
  } etnr_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic early;
    logic clip_hit;
    logic k_zero;
    logic run_zero;
    logic step_ok;
  } etnr_stat_t;

endpackage

### hdl/edge_timed_nrz_byte_receiver_unit.sv
// Edge-timed NRZ byte receiver. Each input transfer is either a line edge (new level plus a
// 32-bit timestamp) or a restart. An edge turns the time since the previous edge into a run of
// bits of the old level, packs the payload bits MSB first and emits each completed byte as one
// output transfer. A restart, or an edge after the frame is complete, is handled without leaving
// the idle state. An edge at bit count zero or one goes from the accepting state straight to
// emitting its single bit. Any other edge passes the accepting state, one that builds the clip
// threshold and one that compares against it. The divider then resolves the six quotient bits,
// one quotient bit per cycle, and the packer consumes one bit per cycle while no completed byte
// has to wait. A run longer than 32 bits skips the divider and is clipped to 32 bits. An edge
// whose run ends the frame stops in the cycle after the bit that ends it. A bit that completes a
// byte waits while the previous byte still sits unaccepted in the output register, so a stalled
// output stretches the item.
module edge_timed_nrz_byte_receiver_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [etnr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [etnr_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic                        in_level,
  input  logic [31:0]                 in_tick,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_data_byte,
  output logic                        out_last,
  output logic                        out_clipped
);
  import etnr_pkg::*;

  etnr_cmd_t  cmd;
  etnr_stat_t stat;

  etnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  etnr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_level      (in_level),
    .in_tick       (in_tick),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_byte (out_data_byte),
    .out_last      (out_last),
    .out_clipped   (out_clipped)
  );

endmodule

### hdl/etnr_ctrl.sv
module etnr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_stall,
  output etnr_pkg::etnr_cmd_t cmd,
  input  etnr_pkg::etnr_stat_t stat
);
  import etnr_pkg::*;

  etnr_state_t state_r;
  etnr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind) begin
            cmd.clear = 1'b1;
          end else if (!stat.frame_done) begin
            cmd.load  = 1'b1;
            // An edge at bit count zero or one gives exactly one bit.
            state_nxt = stat.early ? ST_EMIT : ST_CAP;
          end
        end
      end
      ST_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = stat.clip_hit ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (stat.k_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.run_zero || stat.frame_done) begin
          state_nxt = ST_IDLE;
        end else if (stat.step_ok) begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/etnr_dp.sv
module etnr_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [etnr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [etnr_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_level,
  input  logic [31:0]                 in_tick,
  input  etnr_pkg::etnr_cmd_t         cmd,
  output etnr_pkg::etnr_stat_t        stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_data_byte,
  output logic                        out_last,
  output logic                        out_clipped
);
  import etnr_pkg::*;

  logic [15:0]    bit_period_r;
  logic [7:0]     header_bits_r;
  logic [15:0]    payload_bytes_r;

  logic [BCW-1:0] bit_count_r;
  logic           prev_level_r;
  logic [31:0]    prev_tick_r;
  logic [7:0]     shift_byte_r;
  logic           frame_done_r;
  logic           run_clipped_r;

  logic [31:0]    rem_r;
  logic [CAPW-1:0] cap_r;
  logic [KW-1:0]  k_r;
  logic [QW-1:0]  run_left_r;
  logic           emit_bit_r;
  logic           clip_flag_r;

  logic           out_valid_r;
  logic [7:0]     out_data_byte_r;
  logic           out_last_r;
  logic           out_clipped_r;

  logic [15:0]    period_eff;
  logic [15:0]    pay_eff;
  logic [BCW-1:0] end_cnt;
  logic [BCW-1:0] bc1;
  logic [31:0]    trial;
  logic           clip_hit;
  logic           in_header;
  logic           at_end;
  logic           byte_done;
  logic [7:0]     sb;

  always_comb begin
    period_eff = (bit_period_r == 16'd0) ? 16'd1 : bit_period_r;
    pay_eff    = (payload_bytes_r == 16'd0) ? 16'd1 : payload_bytes_r;
    end_cnt    = BCW'(header_bits_r) + BCW'({pay_eff, 3'b000});
    bc1        = bit_count_r + BCW'(1);
    trial      = 32'(period_eff) << k_r;
    clip_hit   = rem_r >= 32'(cap_r);
    at_end     = bit_count_r >= end_cnt;
    in_header  = bit_count_r < BCW'(header_bits_r);
    sb         = {shift_byte_r[6:0], emit_bit_r};
    byte_done  = !at_end && !in_header && ((bc1[2:0] - header_bits_r[2:0]) == 3'd0);
  end

  always_comb begin
    stat.frame_done = frame_done_r;
    stat.early      = bit_count_r < BCW'(2);
    stat.clip_hit   = clip_hit;
    stat.k_zero     = k_r == '0;
    stat.run_zero   = run_left_r == '0;
    // A bit that completes a byte waits until the output register is free.
    stat.step_ok    = !byte_done || !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r    <= BIT_PERIOD_RST;
      header_bits_r   <= HEADER_BITS_RST;
      payload_bytes_r <= PAYLOAD_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIT_PERIOD:    bit_period_r    <= cfg_wdata;
        CFG_HEADER_BITS:   header_bits_r   <= cfg_wdata[7:0];
        CFG_PAYLOAD_BYTES: payload_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      bit_count_r   <= '0;
      prev_level_r  <= 1'b0;
      prev_tick_r   <= '0;
      shift_byte_r  <= '0;
      frame_done_r  <= 1'b0;
      run_clipped_r <= 1'b0;
    end else if (cmd.load) begin
      prev_level_r <= in_level;
      prev_tick_r  <= in_tick;
    end else if (cmd.step) begin
      if (at_end) begin
        frame_done_r <= 1'b1;
      end else if (in_header) begin
        bit_count_r <= bc1;
      end else begin
        bit_count_r <= bc1;
        if (byte_done) begin
          shift_byte_r  <= '0;
          run_clipped_r <= 1'b0;
          if (bc1 == end_cnt) begin
            frame_done_r <= 1'b1;
          end
        end else begin
          shift_byte_r  <= sb;
          run_clipped_r <= run_clipped_r | clip_flag_r;
        end
      end
    end
  end

  // Run length: elapsed time, clip test and short restoring divide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_left_r <= '0;
      k_r        <= '0;
    end else if (cmd.load) begin
      rem_r       <= in_tick - prev_tick_r;
      emit_bit_r  <= (bit_count_r == '0) ? 1'b0 : prev_level_r;
      clip_flag_r <= 1'b0;
      run_left_r  <= (bit_count_r < BCW'(2)) ? QW'(1) : '0;
    end else if (cmd.cap) begin
      cap_r <= CAPW'(period_eff) * CAPW'(MAX_RUN + 1);
    end else if (cmd.cmp) begin
      if (clip_hit) begin
        run_left_r  <= QW'(MAX_RUN);
        clip_flag_r <= 1'b1;
      end else begin
        run_left_r <= '0;
        k_r        <= KW'(QW - 1);
      end
    end else if (cmd.div) begin
      if (rem_r >= trial) begin
        rem_r           <= rem_r - trial;
        run_left_r[k_r] <= 1'b1;
      end
      k_r <= k_r - KW'(1);
    end else if (cmd.step) begin
      run_left_r <= run_left_r - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && byte_done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && byte_done) begin
      out_data_byte_r <= sb;
      out_last_r      <= bc1 == end_cnt;
      out_clipped_r   <= run_clipped_r | clip_flag_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_byte_r;
  assign out_last      = out_last_r;
  assign out_clipped   = out_clipped_r;

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && byte_done && (bc1 == end_cnt) |=> frame_done_r)
    else $error("last byte did not end the frame");

  a_done_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done_r && !cmd.clear |=> $stable(bit_count_r) && frame_done_r)
    else $error("finished frame changed its bit count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && byte_done |-> !out_valid_r || !out_stall)
    else $error("byte written over a waiting result");

  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    run_left_r <= QW'(MAX_RUN))
    else $error("run length beyond the clip limit");

endmodule

### verif/tb_edge_timed_nrz_byte_receiver_unit.sv
`timescale 1ns / 1ps

module tb_edge_timed_nrz_byte_receiver_unit;
  import etnr_pkg::*;

  localparam bit EV_EDGE = 1'b0;
  localparam bit EV_RESTART = 1'b1;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_SETTING = 28;
  localparam int DRAIN_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       clipped;
  } rx_byte_t;

  typedef enum {ROW_LINE, ROW_REGS} row_op_t;

  typedef struct {
    row_op_t     op;
    bit          kind;
    bit          level;
    logic [31:0] tick;
    logic [15:0] bp;
    logic [7:0]  hb;
    logic [15:0] pb;
    bit          typed;
    rx_byte_t    want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_kind = 1'b0;
  logic                in_level = 1'b0;
  logic [31:0]         in_tick = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [7:0]          out_data_byte;
  logic                out_last;
  logic                out_clipped;

  edge_timed_nrz_byte_receiver_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_level     (in_level),
    .in_tick      (in_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_byte(out_data_byte),
    .out_last     (out_last),
    .out_clipped  (out_clipped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies and the decoder state that the expected bytes are computed from.
  logic [15:0] per_ticks = BIT_PERIOD_RST;
  logic [7:0]  hdr_bits = HEADER_BITS_RST;
  logic [15:0] pay_bytes = PAYLOAD_BYTES_RST;
  int unsigned rx_bits = 0;
  bit          rx_level = 1'b0;
  logic [31:0] rx_tick = '0;
  logic [7:0]  rx_shift = '0;
  bit          rx_done = 1'b0;
  bit          rx_clip = 1'b0;

  rx_byte_t step_bytes[$];
  rx_byte_t pending_bytes[$];
  stim_row_t dir_rows[$];

  int mismatches = 0;
  int tx_idle_pct = 11;
  int rx_idle_pct = 88;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  task automatic clock_in_bit(input bit b, input bit from_clip);
    int unsigned frame_end;
    frame_end = int'(hdr_bits) + 8 * ((pay_bytes == 16'd0) ? 1 : int'(pay_bytes));
    if (rx_done) return;
    if (rx_bits >= frame_end) begin
      rx_done = 1'b1;
      return;
    end
    if (rx_bits < hdr_bits) begin
      rx_bits++;
      return;
    end
    rx_shift = {rx_shift[6:0], b};
    if (from_clip) rx_clip = 1'b1;
    rx_bits++;
    if (((rx_bits - hdr_bits) % 8) == 0) begin
      step_bytes.push_back('{data: rx_shift, last: (rx_bits == frame_end), clipped: rx_clip});
      if (rx_bits == frame_end) rx_done = 1'b1;
      rx_clip = 1'b0;
      rx_shift = '0;
    end
  endtask

  task automatic predict_line_event(input bit kind, input bit level, input logic [31:0] tick);
    logic [31:0] elapsed;
    logic [31:0] period;
    logic [31:0] run_len;
    bit          clip;
    int unsigned i;
    if (kind == EV_RESTART) begin
      rx_bits = 0;
      rx_level = 1'b0;
      rx_tick = '0;
      rx_shift = '0;
      rx_done = 1'b0;
      rx_clip = 1'b0;
      return;
    end
    if (rx_done) return;
    // An edge taken at bit count zero or one yields one bit, regardless of timing.
    if (rx_bits == 0) begin
      clock_in_bit(1'b0, 1'b0);
    end else if (rx_bits == 1) begin
      clock_in_bit(rx_level, 1'b0);
    end else begin
      elapsed = tick - rx_tick;
      period = (per_ticks == 16'd0) ? 32'd1 : 32'(per_ticks);
      run_len = elapsed / period;
      clip = (run_len > MAX_RUN);
      if (clip) run_len = MAX_RUN;
      for (i = 0; i < run_len; i++) clock_in_bit(rx_level, clip);
    end
    rx_level = level;
    rx_tick = tick;
  endtask

  task automatic offer(input bit kind, input bit level, input logic [31:0] tick, input bit typed,
                       input rx_byte_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_level <= level;
    in_tick <= tick;
    do @(posedge clk); while (in_stall);
    step_bytes.delete();
    predict_line_event(kind, level, tick);
    if (typed) begin
      pending_bytes.push_back(want);
    end else begin
      foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
    end
  endtask

  // An edge that emits nothing may still be busy, so wait out the longest item as well.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] bp, input logic [7:0] hb, input logic [15:0] pb);
    settle_idle();
    per_ticks = bp;
    hdr_bits = hb;
    pay_bytes = pb;
    cfg_we <= 1'b1;
    cfg_index <= CFG_BIT_PERIOD;
    cfg_wdata <= bp;
    @(posedge clk);
    cfg_index <= CFG_HEADER_BITS;
    cfg_wdata <= {8'h00, hb};
    @(posedge clk);
    cfg_index <= CFG_PAYLOAD_BYTES;
    cfg_wdata <= pb;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly whole frames of plausible edge timing, with some noise and broken timing mixed in.
  task automatic random_traffic(input int budget);
    int          sent;
    int          edges;
    int          kmax;
    int          r;
    int unsigned step_span;
    int unsigned period;
    logic [31:0] t;
    bit          lvl;
    bit          kind;
    sent = 0;
    while (sent < budget) begin
      period = (per_ticks == 16'd0) ? 1 : per_ticks;
      kmax = (hdr_bits > 8'd64) ? 32 : 9;
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(4, 1)) begin
          kind = ($urandom_range(7) == 0) ? EV_RESTART : EV_EDGE;
          if (kind == EV_RESTART || !rx_done) sent++;
          offer(kind, 1'($urandom_range(1)), $urandom(), 1'b0, '0);
        end
      end else begin
        offer(EV_RESTART, 1'($urandom_range(1)), $urandom(), 1'b0, '0);
        sent++;
        t = $urandom();
        lvl = 1'($urandom_range(1));
        edges = 0;
        while (!rx_done && edges < 48 && sent < budget) begin
          offer(EV_EDGE, lvl, t, 1'b0, '0);
          sent++;
          edges++;
          r = $urandom_range(99);
          if (r < 4) begin
            t = $urandom();
          end else begin
            if (r < 9) step_span = 0;
            else if (r < 19) step_span = $urandom_range(70, 33);
            else step_span = $urandom_range(kmax, 1);
            t = t + step_span * period + $urandom_range(period - 1);
          end
          if ($urandom_range(9) != 0) lvl = !lvl;
        end
      end
    end
  endtask

  task automatic log_mismatch(input string what, input rx_byte_t got, input bit have_want,
                              input rx_byte_t want);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want)
        $display("%0t %s: expected data=%02h last=%0b clipped=%0b, got data=%02h last=%0b clipped=%0b",
                 $realtime, what, want.data, want.last, want.clipped, got.data, got.last,
                 got.clipped);
      else
        $display("%0t %s: got data=%02h last=%0b clipped=%0b", $realtime, what, got.data,
                 got.last, got.clipped);
    end
  endtask

  function automatic stim_row_t line_row(input bit kind, input bit level, input logic [31:0] tick);
    stim_row_t row;
    row.op = ROW_LINE;
    row.kind = kind;
    row.level = level;
    row.tick = tick;
    row.bp = '0;
    row.hb = '0;
    row.pb = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t byte_row(input bit level, input logic [31:0] tick,
                                         input logic [7:0] data, input bit last, input bit clipped);
    stim_row_t row;
    row = line_row(EV_EDGE, level, tick);
    row.typed = 1'b1;
    row.want = '{data: data, last: last, clipped: clipped};
    return row;
  endfunction

  function automatic stim_row_t regs_row(input logic [15:0] bp, input logic [7:0] hb,
                                         input logic [15:0] pb);
    stim_row_t row;
    row = line_row(EV_EDGE, 1'b0, '0);
    row.op = ROW_REGS;
    row.bp = bp;
    row.hb = hb;
    row.pb = pb;
    return row;
  endfunction

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : byte_check
    rx_byte_t got;
    rx_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{data: out_data_byte, last: out_last, clipped: out_clipped};
      if (pending_bytes.size() == 0) begin
        log_mismatch("unexpected byte", got, 1'b0, got);
      end else begin
        want = pending_bytes.pop_front();
        if (got.data !== want.data || got.last !== want.last || got.clipped !== want.clipped)
          log_mismatch("byte mismatch", got, 1'b1, want);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int p;
    int s;
    int wait_cycles;

    // Reset settings: 1000 ticks per bit, 3 header bits, 13 payload bytes.
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd0));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'd5));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd8005));
    dir_rows.push_back(byte_row(1'b0, 32'd9005, 8'h01, 1'b0, 1'b0));
    dir_rows.push_back(byte_row(1'b1, 32'd18004, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'd58004));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd82004));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'd114004));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd200000));
    dir_rows.push_back(line_row(EV_RESTART, 1'b1, 32'hFFFF_FFFF));
    // Smallest settings; the last edge's timestamp wraps past zero.
    dir_rows.push_back(regs_row(16'd1, 8'd0, 16'd1));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'hFFFF_FFF0));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'hFFFF_FFF8));
    dir_rows.push_back(byte_row(1'b1, 32'd4, 8'h40, 1'b1, 1'b0));
    dir_rows.push_back(line_row(EV_RESTART, 1'b0, 32'd0));
    dir_rows.push_back(regs_row(16'hFFFF, 8'hFF, 16'hFFFF));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'd0));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'h7FFF_FFFF));
    dir_rows.push_back(line_row(EV_RESTART, 1'b1, 32'd0));
    // A zero bit period and a zero payload size both act as one.
    dir_rows.push_back(regs_row(16'd0, 8'd8, 16'd0));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd100));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'd200));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd206));
    dir_rows.push_back(byte_row(1'b0, 32'd214, 8'hFF, 1'b1, 1'b0));
    dir_rows.push_back(line_row(EV_RESTART, 1'b0, 32'd0));
    // Shrinking the payload below the bits already taken ends the frame on the next bit.
    dir_rows.push_back(regs_row(16'd10, 8'd0, 16'd4));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd0));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'd5));
    dir_rows.push_back(line_row(EV_EDGE, 1'b1, 32'd225));
    dir_rows.push_back(regs_row(16'd10, 8'd0, 16'd2));
    dir_rows.push_back(line_row(EV_EDGE, 1'b0, 32'd1000));
    dir_rows.push_back(line_row(EV_RESTART, 1'b1, 32'd0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].op == ROW_REGS)
        write_regs(dir_rows[r].bp, dir_rows[r].hb, dir_rows[r].pb);
      else
        offer(dir_rows[r].kind, dir_rows[r].level, dir_rows[r].tick, dir_rows[r].typed,
              dir_rows[r].want);
    end

    for (p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 11 : (p == 1) ? 88 : 0;
      rx_idle_pct = (p == 0) ? 88 : (p == 1) ? 11 : 0;
      for (s = 0; s < 3; s++) begin
        if (s == 0 && p == 0)
          write_regs(16'd1, 8'd0, 16'd1);
        else if (s == 0 && p == 1)
          write_regs(16'hFFFF, 8'hFF, 16'hFFFF);
        else if (s == 0)
          write_regs(16'd0, 8'($urandom_range(12)), 16'd0);
        else
          write_regs(16'($urandom_range(2000, 1)), 8'($urandom_range(12)),
                     16'($urandom_range(8, 1)));
        // Hold the output off for a long stretch so the block backs up into its input.
        if (p == 2 && s == 1) hold_reqs++;
        random_traffic(ITEMS_PER_SETTING);
      end
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_bytes.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_bytes.size() != 0) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (mismatches == 0)
        $display("Simulation PASSED");
      else
        $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

### files.f
hdl/etnr_pkg.sv
hdl/etnr_ctrl.sv
hdl/etnr_dp.sv
hdl/edge_timed_nrz_byte_receiver_unit.sv
verif/tb_edge_timed_nrz_byte_receiver_unit.sv
